@@ src/oxygen_percent_from_filtered_adc_macros.svh @@
// Assertion macros shared by the oxygen percentage block.
`ifndef OXYGEN_PERCENT_FROM_FILTERED_ADC_MACROS_SVH
`define OXYGEN_PERCENT_FROM_FILTERED_ADC_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge outside reset.
`define OXPCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define OXPCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OXPCT_ASSERT(label, prop, msg)
`define OXPCT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/oxpct_pkg.sv @@
// Types and constants of the oxygen percentage block.
`default_nettype none
package oxpct_pkg;

    localparam int CODE_W   = 16;
    localparam int TENTHS_W = 10;
    localparam int PROD_W   = 24;

    localparam logic [7:0]          AIR_TENTHS  = 8'd209;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX  = 10'd999;
    localparam logic [CODE_W-1:0]   ERROR_LIMIT = 16'd2;
    localparam logic [CODE_W-1:0]   CAL_RESET   = 16'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

@@ src/oxpct_ema.sv @@
// Rounding exponential moving average with a 16-bit accumulator.
`default_nettype none
module oxpct_ema
    import oxpct_pkg::*;
#(
    parameter int FILTER_SHIFT = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  logic [CODE_W-1:0] code,
    output logic [CODE_W-1:0] filt
);

    localparam logic [CODE_W:0] ROUND = (CODE_W+1)'(1) << (FILTER_SHIFT - 1);

    logic [CODE_W-1:0] acc_reg;
    logic [CODE_W-1:0] acc_next;
    logic [CODE_W-1:0] acc_sum;
    logic [CODE_W:0]   rounded;

    always_comb
    begin
        acc_sum  = acc_reg + code;
        // The rounding sum is one bit wider so that it cannot wrap.
        rounded  = {1'b0, acc_sum} + ROUND;
        filt     = CODE_W'(rounded >> FILTER_SHIFT);
        acc_next = acc_sum - filt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (update)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

@@ src/oxpct_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
`include "oxygen_percent_from_filtered_adc_macros.svh"
module oxpct_div
    import oxpct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [CODE_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

    logic [PROD_W-1:0] shift_reg;
    logic [PROD_W-1:0] shift_next;
    logic [CODE_W-1:0] rem_reg;
    logic [CODE_W-1:0] rem_next;
    logic [CODE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CODE_W+1:0] trial;

    // A zero divisor lets every trial pass, so the quotient comes out all ones.
    always_comb
    begin
        trial      = {1'b0, rem_reg, shift_reg[PROD_W-1]} - {2'b00, dvs_reg};
        shift_next = {shift_reg[PROD_W-2:0], ~trial[CODE_W+1]};
        if (trial[CODE_W+1])
        begin
            rem_next = {rem_reg[CODE_W-2:0], shift_reg[PROD_W-1]};
        end
        else
        begin
            rem_next = trial[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = shift_reg;

    `OXPCT_ASSERT(a_start_idle, start |-> !busy_reg, "divider started while busy")
    `OXPCT_ASSERT_ALWAYS(a_done_not_busy, done_reg |-> !busy_reg, "divider done while busy")
    `OXPCT_ASSERT(a_last_step_done, (busy_reg && cnt_reg == LAST && !start) |=> done_reg,
        "divider missed its done pulse")

endmodule
`default_nettype wire

@@ src/oxygen_percent_from_filtered_adc.sv @@
// Top level: filtered galvanic sensor code to oxygen in tenths of a percent.
// An accepted request goes through ST_MUL, ST_DIV, then ST_DONE, which waits for out_free.
// New requests are taken only in ST_IDLE, after the 24-step serial divider is done.
// The output register lets the block take the next request while a result waits.
// Reset clears the filter accumulator and the peak; the calibration code becomes 100.
`default_nettype none
`include "oxygen_percent_from_filtered_adc_macros.svh"
module oxygen_percent_from_filtered_adc
    import oxpct_pkg::*;
#(
    parameter int FILTER_SHIFT = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [CODE_W-1:0]   adc_sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic        [CODE_W-1:0]   air_calibration_code,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic        [CODE_W-1:0]   filtered_code,
    output logic        [TENTHS_W-1:0] oxygen_tenths,
    output logic                       sensor_error,
    output logic        [TENTHS_W-1:0] peak_tenths
);

    state_t              state_reg;
    state_t              state_next;
    logic [CODE_W-1:0]   cal_reg;
    logic [CODE_W-1:0]   filt_reg;
    logic [CODE_W-1:0]   ema_filt;
    logic [TENTHS_W-1:0] peak_reg;
    logic [TENTHS_W-1:0] peak_next;
    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_filt_reg;
    logic [TENTHS_W-1:0] out_tenths_reg;
    logic                out_err_reg;
    logic [TENTHS_W-1:0] out_peak_reg;
    logic                accept;
    logic                div_start;
    logic                load_out;
    logic                out_free;
    div_stat_t           div_stat;
    logic [PROD_W-1:0]   quotient;
    logic [PROD_W-1:0]   product;
    logic [TENTHS_W-1:0] tenths_sat;
    logic                err;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    oxpct_ema #(
        .FILTER_SHIFT(FILTER_SHIFT)
    ) u_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (accept),
        .code   (adc_sample),
        .filt   (ema_filt)
    );

    // The divider's dividend register holds the product.
    assign product = PROD_W'(filt_reg) * PROD_W'(AIR_TENTHS);

    oxpct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (cal_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        tenths_sat = (quotient > PROD_W'(TENTHS_MAX)) ? TENTHS_MAX : quotient[TENTHS_W-1:0];
        err        = filt_reg <= ERROR_LIMIT;
        peak_next  = (!err && tenths_sat >= peak_reg) ? tenths_sat : peak_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cal_reg       <= CAL_RESET;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                cal_reg <= air_calibration_code;
            end
            if (load_out)
            begin
                peak_reg      <= peak_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            filt_reg <= ema_filt;
        end
        if (load_out)
        begin
            out_filt_reg   <= filt_reg;
            out_tenths_reg <= tenths_sat;
            out_err_reg    <= err;
            out_peak_reg   <= peak_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign filtered_code = out_filt_reg;
    assign oxygen_tenths = out_tenths_reg;
    assign sensor_error  = out_err_reg;
    assign peak_tenths   = out_peak_reg;

    `OXPCT_ASSERT(a_tenths_range, out_valid_reg |-> out_tenths_reg <= TENTHS_MAX,
        "oxygen reading above saturation")
    `OXPCT_ASSERT(a_peak_rises, peak_reg >= $past(peak_reg), "peak reading decreased")
    `OXPCT_ASSERT(a_div_running, (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done),
        "waiting on an idle divider")

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the filtered-ADC oxygen percentage block.
module testbench
    import oxpct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EMA_SHIFT      = 4;
    localparam int DIRECTED_ROWS  = 22;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CODE_W-1:0]   filtered;
        logic [TENTHS_W-1:0] tenths;
        logic                error;
        logic [TENTHS_W-1:0] peak;
    } oxygen_reading_t;

    typedef struct packed {
        logic [CODE_W-1:0] sample;
        logic              typed;
        oxygen_reading_t   want;
    } directed_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [CODE_W-1:0]   adc_sample = '0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic        [CODE_W-1:0]   air_calibration_code = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic        [CODE_W-1:0]   filtered_code;
    logic        [TENTHS_W-1:0] oxygen_tenths;
    logic                       sensor_error;
    logic        [TENTHS_W-1:0] peak_tenths;

    // Predictor state: filter accumulator, held peak and calibration code.
    logic [CODE_W-1:0]   ema_acc = '0;
    logic [TENTHS_W-1:0] peak_hold = '0;
    logic [CODE_W-1:0]   air_cal = CAL_RESET;

    oxygen_reading_t expected_readings [$];

    int unsigned mismatches = 0;
    int unsigned samples_sent = 0;
    int unsigned readings_checked = 0;
    int unsigned error_readings = 0;
    int unsigned saturated_readings = 0;
    int unsigned cal_settings = 1;
    int unsigned idle_pct = 0;
    int unsigned hold_off = 0;
    int unsigned stuck_cycles = 0;

    // The first three rows start from reset, where the filter and the peak are zero.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, '{16'd0, 10'd0, 1'b1, 10'd0}},
        '{16'd24,   1'b1, '{16'd2, 10'd4, 1'b1, 10'd0}},
        '{16'd30,   1'b1, '{16'd3, 10'd6, 1'b0, 10'd6}},
        '{16'd40,   1'b0, '0},
        '{16'd48,   1'b0, '0},
        '{16'd64,   1'b0, '0},
        '{16'd100,  1'b0, '0},
        '{16'd200,  1'b0, '0},
        '{16'd60,   1'b0, '0},
        '{16'd20,   1'b0, '0},
        '{16'd1,    1'b0, '0},
        '{16'd0,    1'b0, '0},
        '{16'd0,    1'b0, '0},
        '{16'h7FFF, 1'b0, '0},
        '{16'h8000, 1'b0, '0},
        '{16'hFFFF, 1'b0, '0},
        '{16'h0001, 1'b0, '0},
        '{16'hAAAA, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'h0000, 1'b0, '0},
        '{16'h0000, 1'b0, '0},
        '{16'h0000, 1'b0, '0}
    };

    oxygen_percent_from_filtered_adc #(
        .FILTER_SHIFT(EMA_SHIFT)
    ) DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .adc_sample           (adc_sample),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .air_calibration_code (air_calibration_code),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .filtered_code        (filtered_code),
        .oxygen_tenths        (oxygen_tenths),
        .sensor_error         (sensor_error),
        .peak_tenths          (peak_tenths)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic oxygen_reading_t predict_reading(input logic [CODE_W-1:0] code);
        logic [CODE_W:0]   rounded;
        logic [PROD_W-1:0] scaled;
        logic [PROD_W-1:0] quotient;
        oxygen_reading_t   r;
        ema_acc    = ema_acc + code;
        rounded    = {1'b0, ema_acc} + ((CODE_W+1)'(1) << (EMA_SHIFT - 1));
        r.filtered = CODE_W'(rounded >> EMA_SHIFT);
        ema_acc    = ema_acc - r.filtered;
        scaled     = PROD_W'(r.filtered) * PROD_W'(AIR_TENTHS);
        // An out-of-range calibration of zero skips the divide and pins the reading.
        if (air_cal == '0)
            quotient = PROD_W'(TENTHS_MAX);
        else
            quotient = scaled / PROD_W'(air_cal);
        r.tenths = (quotient > PROD_W'(TENTHS_MAX)) ? TENTHS_MAX : quotient[TENTHS_W-1:0];
        r.error  = (r.filtered <= ERROR_LIMIT);
        if (!r.error && r.tenths >= peak_hold)
            peak_hold = r.tenths;
        r.peak = peak_hold;
        return r;
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("reading %0d: %s expected %0d, got %0d",
                         readings_checked, field, want, got);
        end
    endfunction

    task automatic send_sample(input logic [CODE_W-1:0] code, input logic typed,
                               input oxygen_reading_t typed_want);
        oxygen_reading_t predicted;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_reading(code);
        expected_readings.push_back(typed ? typed_want : predicted);
        samples_sent++;
    endtask

    // The calibration register only changes once every pending reading is back.
    task automatic write_calibration(input logic [CODE_W-1:0] code);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        cfg_valid            <= 1'b1;
        air_calibration_code <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        air_cal = code;
        cal_settings++;
    endtask

    // Samples come in runs around a level so the filter settles, drains to the
    // error region, or wanders through wrapped accumulator values.
    task automatic drive_sample_bursts(input int unsigned count);
        int unsigned sent;
        int unsigned run_len;
        int unsigned level;
        int unsigned spread;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    level  = 0;
                    spread = 0;
                end
                2, 3:
                begin
                    level  = $urandom_range(0, 6);
                    spread = 4;
                end
                4, 5, 6:
                begin
                    level  = $urandom_range(0, 4095);
                    spread = 64;
                end
                7:
                begin
                    level  = air_cal >> $urandom_range(0, 3);
                    spread = 16;
                end
                default:
                begin
                    level  = 0;
                    spread = 65535;
                end
            endcase
            run_len = $urandom_range(1, 40);
            repeat (run_len)
            begin
                if (sent < count)
                begin
                    send_sample(CODE_W'(level + $urandom_range(0, spread) - (spread >> 1)),
                                1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: stalls out_ready in short random bursts.
    always @(posedge clk)
    begin
        if (hold_off != 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct / 2)
        begin
            hold_off  <= $urandom_range(1, 7) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        oxygen_reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            readings_checked++;
            if (sensor_error)
                error_readings++;
            if (oxygen_tenths == TENTHS_MAX)
                saturated_readings++;
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reading %0d: none expected, got filtered %0d tenths %0d",
                             readings_checked, filtered_code, oxygen_tenths);
            end
            else
            begin
                want = expected_readings.pop_front();
                compare_field("filtered_code", want.filtered, filtered_code);
                compare_field("oxygen_tenths", want.tenths, oxygen_tenths);
                compare_field("sensor_error", want.error, sensor_error);
                compare_field("peak_tenths", want.peak, peak_tenths);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", stuck_cycles);
            $display("FAILURE");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].want);

        write_calibration(16'd1);
        idle_pct = 30;
        drive_sample_bursts(150);

        write_calibration(16'hFFFF);
        idle_pct = 0;
        drive_sample_bursts(150);

        write_calibration(16'd0);
        idle_pct = 50;
        drive_sample_bursts(120);

        write_calibration(16'd209);
        idle_pct = 20;
        drive_sample_bursts(150);

        write_calibration(CODE_W'($urandom_range(1, 65535)));
        idle_pct = 40;
        drive_sample_bursts(150);

        // Closing stretch runs at full rate on both sides.
        write_calibration(CODE_W'($urandom_range(1, 2000)));
        idle_pct = 0;
        drive_sample_bursts(150);
        in_valid <= 1'b0;

        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples under %0d calibration codes, %0d readings checked.",
                 samples_sent, cal_settings, readings_checked);
        $display("%0d readings flagged a sensor error, %0d hit the saturation limit.",
                 error_readings, saturated_readings);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
